@@ hdl/spct_pkg.sv @@
// ---------------------------------------------------------------------------
// Prime count table package
// Shared widths, defaults and control types for the prime count table block.
// ---------------------------------------------------------------------------
`default_nettype none

package spct_pkg;

  localparam int NUM_W          = 32;
  localparam int CNT_W          = 16;
  localparam int DEF_LIMIT      = 65536;
  localparam int DEF_MAX_PRIMES = 8192;
  localparam int FIRST_PRIME    = 2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [NUM_W-1:0] num_t;

  // Table access controls and build status from the sieve sequencer.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic done;
  } build_ctl_t;

endpackage

`default_nettype wire

@@ hdl/spct_stream_if.sv @@
// ---------------------------------------------------------------------------
// Prime count table channels
// Valid/ready channels for query items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface spct_in_if;
  logic                valid;
  logic                ready;
  spct_pkg::num_t      number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface spct_out_if;
  logic                valid;
  logic                ready;
  spct_pkg::cnt_t      prime_count;
  logic                out_of_range;

  modport source (output valid, output prime_count, output out_of_range, input ready);
  modport sink   (input valid, input prime_count, input out_of_range, output ready);
endinterface

`default_nettype wire

@@ hdl/spct_table.sv @@
// ---------------------------------------------------------------------------
// Prime count table memory
// One write port and one registered read port over LIMIT entries.
// ---------------------------------------------------------------------------
`default_nettype none

module spct_table #(
  parameter int LIMIT = spct_pkg::DEF_LIMIT
) (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(LIMIT)-1:0]  rd_addr,
  output      spct_pkg::cnt_t            rd_data,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(LIMIT)-1:0]  wr_addr,
  input  wire spct_pkg::cnt_t            wr_data
);

  spct_pkg::cnt_t mem [LIMIT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/spct_build.sv @@
// ---------------------------------------------------------------------------
// Prime count table builder
// Linear sieve sequencer that fills the table after reset. During the sieve
// an entry holds the smallest prime factor of a struck composite, or zero
// for a number still taken as prime; a final pass turns it into a count.
// ---------------------------------------------------------------------------
`default_nettype none

module spct_build #(
  parameter int LIMIT      = spct_pkg::DEF_LIMIT,
  parameter int MAX_PRIMES = spct_pkg::DEF_MAX_PRIMES
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  output      spct_pkg::build_ctl_t      ctl,
  output      logic [$clog2(LIMIT)-1:0]  rd_addr,
  input  wire spct_pkg::cnt_t            rd_data,
  output      logic [$clog2(LIMIT)-1:0]  wr_addr,
  output      spct_pkg::cnt_t            wr_data
);

  localparam int IDX_W  = $clog2(LIMIT);
  localparam int LIM_W  = IDX_W + 1;
  localparam int PROD_W = 2 * IDX_W;
  localparam int PIDX_W = $clog2(MAX_PRIMES);
  localparam int PF_W   = $clog2(MAX_PRIMES + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LIM_W-1:0]  lim_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [PF_W-1:0]   pf_t;

  localparam lim_t  LimL   = lim_t'(LIMIT);
  localparam lim_t  LimM1L = lim_t'(LIMIT - 1);
  localparam idx_t  LimM1  = idx_t'(LIMIT - 1);
  localparam prod_t LimP   = prod_t'(LIMIT);
  localparam pf_t   MaxP   = pf_t'(MAX_PRIMES);
  localparam lim_t  FirstL = lim_t'(spct_pkg::FIRST_PRIME);
  localparam idx_t  FirstI = idx_t'(spct_pkg::FIRST_PRIME);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_RD_I = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_RD_P = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_MARK = 3'd5;
  localparam logic [2:0] ST_PFX  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]     st_r, st_nxt;
  lim_t           a_r, a_nxt;
  idx_t           i_r, i_nxt;
  pf_t            j_r, j_nxt;
  pf_t            pf_r, pf_nxt;
  idx_t           bv_r, bv_nxt;
  idx_t           p_r, p_nxt;
  prod_t          prod_r, prod_nxt;
  logic           pv_r, pv_nxt;
  idx_t           wa_r, wa_nxt;
  spct_pkg::cnt_t run_r, run_nxt;

  logic           adv_i;
  logic           pl_we;
  logic           pl_re;
  idx_t           pl_q;
  idx_t           plist [MAX_PRIMES];

  always_ff @(posedge clk) begin
    if (pl_we) begin
      plist[pf_r[PIDX_W-1:0]] <= i_r;
    end
    if (pl_re) begin
      pl_q <= plist[j_r[PIDX_W-1:0]];
    end
  end

  always_comb begin
    st_nxt     = st_r;
    a_nxt      = a_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    pf_nxt     = pf_r;
    bv_nxt     = bv_r;
    p_nxt      = p_r;
    prod_nxt   = prod_r;
    pv_nxt     = pv_r;
    wa_nxt     = wa_r;
    run_nxt    = run_r;
    adv_i      = 1'b0;
    pl_we      = 1'b0;
    pl_re      = 1'b0;
    ctl.rd_en  = 1'b0;
    ctl.wr_en  = 1'b0;
    ctl.done   = 1'b0;
    rd_addr    = '0;
    wr_addr    = '0;
    wr_data    = '0;
    case (st_r)
      ST_INIT: begin
        ctl.wr_en = 1'b1;
        wr_addr   = a_r[IDX_W-1:0];
        wr_data   = (a_r < FirstL) ? spct_pkg::cnt_t'(1) : '0;
        if (a_r == LimM1L) begin
          st_nxt = ST_RD_I;
          i_nxt  = FirstI;
          a_nxt  = '0;
        end else begin
          a_nxt = a_r + lim_t'(1);
        end
      end
      ST_RD_I: begin
        ctl.rd_en = 1'b1;
        rd_addr   = i_r;
        st_nxt    = ST_CHK;
      end
      ST_CHK: begin
        if (rd_data == '0 && pf_r < MaxP) begin
          pl_we  = 1'b1;
          pf_nxt = pf_r + pf_t'(1);
        end
        bv_nxt = (rd_data == '0) ? i_r : idx_t'(rd_data);
        j_nxt  = '0;
        st_nxt = ST_RD_P;
      end
      ST_RD_P: begin
        if (j_r == pf_r) begin
          adv_i = 1'b1;
        end else begin
          pl_re  = 1'b1;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        p_nxt    = pl_q;
        prod_nxt = prod_t'(pl_q) * prod_t'(i_r);
        st_nxt   = ST_MARK;
      end
      ST_MARK: begin
        if (prod_r >= LimP) begin
          adv_i = 1'b1;
        end else begin
          ctl.wr_en = 1'b1;
          wr_addr   = prod_r[IDX_W-1:0];
          wr_data   = spct_pkg::cnt_t'(p_r);
          if (p_r == bv_r) begin
            adv_i = 1'b1;
          end else begin
            j_nxt  = j_r + pf_t'(1);
            st_nxt = ST_RD_P;
          end
        end
      end
      ST_PFX: begin
        if (a_r != LimL) begin
          ctl.rd_en = 1'b1;
          rd_addr   = a_r[IDX_W-1:0];
          a_nxt     = a_r + lim_t'(1);
          pv_nxt    = 1'b1;
          wa_nxt    = a_r[IDX_W-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (rd_data == '0 && run_r != '1) begin
            run_nxt = run_r + spct_pkg::cnt_t'(1);
          end
          ctl.wr_en = 1'b1;
          wr_addr   = wa_r;
          wr_data   = run_nxt;
          if (a_r == LimL) begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        ctl.done = 1'b1;
      end
      default: begin
        st_nxt = ST_INIT;
      end
    endcase
    if (adv_i) begin
      if (i_r == LimM1) begin
        st_nxt  = ST_PFX;
        a_nxt   = '0;
        pv_nxt  = 1'b0;
        run_nxt = '0;
      end else begin
        i_nxt  = i_r + idx_t'(1);
        st_nxt = ST_RD_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_INIT;
      a_r   <= '0;
      i_r   <= '0;
      j_r   <= '0;
      pf_r  <= '0;
      pv_r  <= 1'b0;
      run_r <= '0;
    end else begin
      st_r  <= st_nxt;
      a_r   <= a_nxt;
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      pf_r  <= pf_nxt;
      pv_r  <= pv_nxt;
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bv_r   <= bv_nxt;
    p_r    <= p_nxt;
    prod_r <= prod_nxt;
    wa_r   <= wa_nxt;
  end

`ifndef SYNTHESIS
  a_pf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pf_r <= MaxP)
    else $error("prime list count exceeds its depth");
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> ctl.done)
    else $error("build done dropped");
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MARK) && ctl.wr_en |-> (prod_r < LimP) && (p_r != '0))
    else $error("sieve mark out of range or with zero factor");
`endif

endmodule

`default_nettype wire

@@ hdl/sieve_prime_count_table.sv @@
// ---------------------------------------------------------------------------
// Prime count table
// Answers prime-count queries from a table built by a linear sieve.
// ---------------------------------------------------------------------------
//   channel   port      dir   fields
//   query     in_chan   in    number[31:0]
//   result    out_chan  out   prime_count[15:0], out_of_range
//
// After reset the table is built: it is cleared, then each number has its entry read
// and checked, each prime tried against it goes through prime list read, multiply
// and mark, with a list end check when the prime list runs out, and a count pass
// then runs over every entry. in_chan.ready stays low until then.
// Afterwards one query is taken per cycle while the result side is not stalled;
// a result passes through the registered table read and the output register.
// A stalled result holds both stages; the query side stalls only when both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module sieve_prime_count_table #(
  parameter int LIMIT      = spct_pkg::DEF_LIMIT,
  parameter int MAX_PRIMES = spct_pkg::DEF_MAX_PRIMES
) (
  input wire logic   clk,
  input wire logic   rst_n,
  spct_in_if.sink    in_chan,
  spct_out_if.source out_chan
);

  localparam int IDX_W = $clog2(LIMIT);
  localparam spct_pkg::num_t LimN = spct_pkg::num_t'(LIMIT);

  spct_pkg::build_ctl_t bctl;
  logic [IDX_W-1:0]     b_rd_addr;
  logic [IDX_W-1:0]     b_wr_addr;
  spct_pkg::cnt_t       b_wr_data;
  logic                 t_rd_en;
  logic [IDX_W-1:0]     t_rd_addr;
  spct_pkg::cnt_t       t_rd_data;

  logic                 in_fire;
  logic                 s2_free;
  logic                 s1_move;
  logic                 v1_r, v1_nxt;
  logic                 oor1_r;
  logic                 ov_r, ov_nxt;
  spct_pkg::cnt_t       cnt_r;
  logic                 oor_r;

  spct_build #(
    .LIMIT      (LIMIT),
    .MAX_PRIMES (MAX_PRIMES)
  ) u_build (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bctl),
    .rd_addr (b_rd_addr),
    .rd_data (t_rd_data),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data)
  );

  spct_table #(
    .LIMIT (LIMIT)
  ) u_table (
    .clk     (clk),
    .rd_en   (t_rd_en),
    .rd_addr (t_rd_addr),
    .rd_data (t_rd_data),
    .wr_en   (bctl.wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data)
  );

  assign s2_free       = !ov_r || out_chan.ready;
  assign s1_move       = v1_r && s2_free;
  assign in_chan.ready = bctl.done && (!v1_r || s2_free);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign t_rd_en   = bctl.done ? in_fire : bctl.rd_en;
  assign t_rd_addr = bctl.done ? in_chan.number[IDX_W-1:0] : b_rd_addr;

  always_comb begin
    v1_nxt = v1_r;
    if (in_fire) begin
      v1_nxt = 1'b1;
    end else if (s1_move) begin
      v1_nxt = 1'b0;
    end
    ov_nxt = ov_r;
    if (s1_move) begin
      ov_nxt = 1'b1;
    end else if (out_chan.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      oor1_r <= (in_chan.number >= LimN);
    end
    if (s1_move) begin
      cnt_r <= oor1_r ? '0 : t_rd_data;
      oor_r <= oor1_r;
    end
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.prime_count  = cnt_r;
  assign out_chan.out_of_range = oor_r;

`ifndef SYNTHESIS
  a_ready_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> bctl.done)
    else $error("query taken before the table is built");
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.out_of_range |-> out_chan.prime_count == '0)
    else $error("out-of-range result with nonzero count");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && out_chan.valid && !out_chan.ready |=> v1_r)
    else $error("pending item lost under output stall");
  a_no_build_write: assert property (@(posedge clk) disable iff (!rst_n)
    bctl.done |-> !bctl.wr_en)
    else $error("table written after build");
`endif

endmodule

`default_nettype wire
